// ===== src/rtp_header_parser_assert.svh =====
// ----------------------------------------------------------------------------
// rtp_header_parser_assert
// Assertion macros for the RTP header parser, clocked on aclk, off in reset.
// ----------------------------------------------------------------------------
`ifndef RTP_HEADER_PARSER_ASSERT_SVH
`define RTP_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define RHP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rtp_header_parser: same-cycle check failed");

// next-cycle implication
`define RHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rtp_header_parser: next-cycle check failed");

`endif

// ===== src/rhp_pkg.sv =====
// ----------------------------------------------------------------------------
// rhp_pkg
// Types and constants shared by the RTP header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhp_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [11:0] packet_length;
        logic        last_byte;
    } rhp_in_t;

    typedef struct packed {
        logic        is_summary;
        logic [2:0]  status;
        logic        marker;
        logic [6:0]  ptype;
        logic [15:0] sequence_res;
        logic [31:0] timestamp;
        logic [31:0] ssrc;
        logic [3:0]  csrc_count;
        logic [7:0]  ext_id;
        logic [11:0] offset;
        logic [11:0] length;
        logic [7:0]  padding_count;
    } rhp_out_t;

    typedef enum logic [1:0] {
        PROF_NONE,
        PROF_ONE_BYTE,
        PROF_TWO_BYTE
    } rhp_prof_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT_FIXED = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_SHORT_CSRC  = 3'd3;
    localparam logic [2:0] ST_SHORT_EXT   = 3'd4;
    localparam logic [2:0] ST_EXT_OVERRUN = 3'd5;
    localparam logic [2:0] ST_ZERO_PAD    = 3'd6;
    localparam logic [2:0] ST_PAD_OVERRUN = 3'd7;

    localparam logic [15:0] PROFILE_ONE_BYTE = 16'hBEDE;
    localparam logic [15:0] PROFILE_TWO_BYTE = 16'h1000;
    localparam logic [15:0] PROFILE_TWO_MASK = 16'hFFF0;
    localparam logic [1:0]  RTP_VERSION      = 2'd2;
    localparam logic [3:0]  ID_RESERVED      = 4'd15;
    localparam int          FIXED_BYTES      = 12;

endpackage

// ===== src/rtp_header_parser.sv =====
// ----------------------------------------------------------------------------
// rtp_header_parser
// Streaming RTP header and header-extension parser, one byte per request.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle and returns at most one result per byte,
// registered, in the cycle after the byte is taken. A new byte is taken in every
// cycle unless the result register holds a result that m_ready has not taken;
// the single pass of byte-wise state update between the input handshake and
// the result register sets this rate of one byte per cycle. No reset sweep.
`timescale 1ns / 1ps

module rtp_header_parser
    import rhp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rhp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rhp_out_t m_data
);

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CW = ((PW > 19) ? PW : 19) + 1;

    logic [PW-1:0] pos_reg, pos_next;
    logic [1:0]    flags_reg, flags_next;
    logic          marker_reg, marker_next;
    logic [6:0]    type_reg, type_next;
    logic [15:0]   seq_reg, seq_next;
    logic [31:0]   ts_reg, ts_next;
    logic [31:0]   ssrc_reg, ssrc_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [15:0]   prof_reg, prof_next;
    logic [17:0]   area_reg, area_next;
    logic [17:0]   cursor_reg, cursor_next;
    logic [8:0]    pend_reg, pend_next;
    logic          stop_reg, stop_next;
    logic [2:0]    err_reg, err_next;

    logic          m_valid_reg;
    rhp_out_t      m_data_reg;
    rhp_out_t      res;
    logic          res_valid;
    logic          take;

    rhp_prof_t     kind;
    logic [CW-1:0] pos_w, size_w, d_w, base_w, e_w, rel_w, po_w, pad_w, hl_w;
    logic [CW-1:0] len1_w;
    logic [7:0]    d;
    logic [2:0]    st;
    logic          rec;
    logic [7:0]    rec_id;
    logic [CW-1:0] rec_off, rec_len;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (prof_reg == PROFILE_ONE_BYTE) begin
            kind = PROF_ONE_BYTE;
        end else if ((prof_reg & PROFILE_TWO_MASK) == PROFILE_TWO_BYTE) begin
            kind = PROF_TWO_BYTE;
        end else begin
            kind = PROF_NONE;
        end
    end

    always_comb begin
        d           = s_data.data_byte;
        d_w         = CW'(d);
        size_w      = CW'(s_data.packet_length);
        pos_w       = CW'(pos_reg);
        pos_next    = pos_reg;
        flags_next  = flags_reg;
        marker_next = marker_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        ts_next     = ts_reg;
        ssrc_next   = ssrc_reg;
        cnt_next    = cnt_reg;
        prof_next   = prof_reg;
        area_next   = area_reg;
        cursor_next = cursor_reg;
        pend_next   = pend_reg;
        stop_next   = stop_reg;
        err_next    = err_reg;
        rec         = 1'b0;
        rec_id      = '0;
        rec_off     = '0;
        rec_len     = '0;
        rel_w       = '0;
        hl_w        = '0;
        len1_w      = '0;
        base_w      = CW'(FIXED_BYTES) + (CW'(cnt_reg) << 2);
        e_w         = base_w + CW'(4);

        if (pos_reg < PW'(MAX_PACKET_BYTES)) begin
            if (pos_reg == '0) begin
                flags_next = d[5:4];
                cnt_next   = d[3:0];
                base_w     = CW'(FIXED_BYTES) + (CW'(d[3:0]) << 2);
                if (size_w < CW'(FIXED_BYTES)) begin
                    err_next = ST_SHORT_FIXED;
                end else if (d[7:6] != RTP_VERSION) begin
                    err_next = ST_BAD_VERSION;
                end else if (size_w < base_w) begin
                    err_next = ST_SHORT_CSRC;
                end else if (d[4] && size_w < base_w + CW'(4)) begin
                    err_next = ST_SHORT_EXT;
                end
            end else if (pos_w == CW'(1)) begin
                marker_next = d[7];
                type_next   = d[6:0];
            end else if (pos_w < CW'(4)) begin
                seq_next = {seq_reg[7:0], d};
            end else if (pos_w < CW'(8)) begin
                ts_next = {ts_reg[23:0], d};
            end else if (pos_w < CW'(FIXED_BYTES)) begin
                ssrc_next = {ssrc_reg[23:0], d};
            end

            if (pos_reg != '0 && err_reg == ST_OK && flags_reg[0]) begin
                if (pos_w == base_w || pos_w == base_w + CW'(1)) begin
                    prof_next = {prof_reg[7:0], d};
                end else if (pos_w == base_w + CW'(2)) begin
                    area_next = {d, 10'b0};
                end else if (pos_w == base_w + CW'(3)) begin
                    area_next = area_reg + {8'b0, d, 2'b0};
                    if (e_w + CW'(area_next) > size_w) begin
                        err_next = ST_EXT_OVERRUN;
                    end
                end else if (pos_w >= e_w && pos_w < e_w + CW'(area_reg)
                             && !stop_reg && kind != PROF_NONE) begin
                    rel_w = pos_w - e_w;
                    if (pend_reg[8]) begin
                        if (CW'(cursor_reg) + CW'(2) + d_w > CW'(area_reg)) begin
                            stop_next = 1'b1;
                        end else begin
                            rec         = 1'b1;
                            rec_id      = pend_reg[7:0];
                            rec_off     = e_w + CW'(cursor_reg) + CW'(2);
                            rec_len     = d_w;
                            cursor_next = 18'(CW'(cursor_reg) + CW'(2) + d_w);
                        end
                        pend_next = '0;
                    end else if (rel_w == CW'(cursor_reg)) begin
                        hl_w = (kind == PROF_ONE_BYTE) ? CW'(1) : CW'(2);
                        len1_w = CW'(d[3:0]) + CW'(1);
                        priority if (CW'(cursor_reg) + hl_w >= CW'(area_reg)) begin
                            stop_next = 1'b1;
                        end else if (d == 8'd0) begin
                            cursor_next = cursor_reg + 18'd1;
                        end else if (kind == PROF_ONE_BYTE) begin
                            if (d[7:4] == ID_RESERVED || d[7:4] == 4'd0 ||
                                CW'(cursor_reg) + CW'(1) + len1_w > CW'(area_reg)) begin
                                stop_next = 1'b1;
                            end else begin
                                rec         = 1'b1;
                                rec_id      = {4'd0, d[7:4]};
                                rec_off     = e_w + CW'(cursor_reg) + CW'(1);
                                rec_len     = len1_w;
                                cursor_next = 18'(CW'(cursor_reg) + CW'(1) + len1_w);
                            end
                        end else begin
                            pend_next = {1'b1, d};
                        end
                    end
                end
            end
            pos_next = pos_reg + PW'(1);
        end

        st    = err_next;
        pad_w = '0;
        po_w  = base_w;
        if (flags_next[0]) begin
            po_w = base_w + CW'(4) + CW'(area_next);
        end
        if (st == ST_OK && flags_next[1] && po_w < size_w) begin
            pad_w = d_w;
            if (d == 8'd0) begin
                st = ST_ZERO_PAD;
            end
        end
        if (st == ST_OK && po_w + pad_w > size_w) begin
            st = ST_PAD_OVERRUN;
        end

        res       = '0;
        res_valid = 1'b0;
        if (s_data.last_byte) begin
            res_valid         = 1'b1;
            res.is_summary    = 1'b1;
            res.status        = st;
            if (st == ST_OK || st >= ST_SHORT_EXT) begin
                res.marker       = marker_next;
                res.ptype        = type_next;
                res.sequence_res = seq_next;
                res.timestamp    = ts_next;
                res.ssrc         = ssrc_next;
                res.csrc_count   = cnt_next;
            end
            if (st == ST_OK) begin
                res.offset = po_w[11:0];
                res.length = 12'(size_w - po_w - pad_w);
            end
            if (st == ST_OK || st == ST_PAD_OVERRUN) begin
                res.padding_count = pad_w[7:0];
            end
        end else if (rec) begin
            res_valid        = 1'b1;
            res.status       = ST_OK;
            res.marker       = marker_next;
            res.ptype        = type_next;
            res.sequence_res = seq_next;
            res.timestamp    = ts_next;
            res.ssrc         = ssrc_next;
            res.csrc_count   = cnt_next;
            res.ext_id       = rec_id;
            res.offset       = rec_off[11:0];
            res.length       = rec_len[11:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && s_data.last_byte)) begin
            pos_reg    <= '0;
            flags_reg  <= '0;
            marker_reg <= '0;
            type_reg   <= '0;
            seq_reg    <= '0;
            ts_reg     <= '0;
            ssrc_reg   <= '0;
            cnt_reg    <= '0;
            prof_reg   <= '0;
            area_reg   <= '0;
            cursor_reg <= '0;
            pend_reg   <= '0;
            stop_reg   <= '0;
            err_reg    <= '0;
        end else if (take) begin
            pos_reg    <= pos_next;
            flags_reg  <= flags_next;
            marker_reg <= marker_next;
            type_reg   <= type_next;
            seq_reg    <= seq_next;
            ts_reg     <= ts_next;
            ssrc_reg   <= ssrc_next;
            cnt_reg    <= cnt_next;
            prof_reg   <= prof_next;
            area_reg   <= area_next;
            cursor_reg <= cursor_next;
            pend_reg   <= pend_next;
            stop_reg   <= stop_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res_valid) begin
            m_data_reg <= res;
        end
    end

`include "rtp_header_parser_assert.svh"

    `RHP_ASSERT_NOW(a_rec_clean, m_valid && !m_data.is_summary, m_data.status == ST_OK && m_data.padding_count == 8'd0)
    `RHP_ASSERT_NOW(a_err_no_payload, m_valid && m_data.is_summary && m_data.status != ST_OK, m_data.offset == 12'd0 && m_data.length == 12'd0)
    `RHP_ASSERT_NEXT(a_last_clears, s_valid && s_ready && s_data.last_byte, pos_reg == '0 && err_reg == ST_OK)
    `RHP_ASSERT_NOW(a_pos_bound, 1'b1, pos_reg <= PW'(MAX_PACKET_BYTES))

endmodule

// ===== tb/rhp_checker.sv =====
// ----------------------------------------------------------------------------
// rhp_checker
// Watches both channels of the RTP header parser, predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhp_checker
    import rhp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  rhp_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  rhp_out_t m_data,
    output int       error_count,
    output int       pending_count
);

    localparam int MAX_BYTES = 2048;

    logic [11:0] pos_q;
    logic [1:0]  flags_q;
    logic        marker_q;
    logic [6:0]  ptype_q;
    logic [15:0] seq_q;
    logic [31:0] ts_q;
    logic [31:0] ssrc_q;
    logic [3:0]  cc_q;
    logic [15:0] profile_q;
    int          area_q;
    int          cursor_q;
    logic [8:0]  pend_q;
    logic        stopped_q;
    logic [2:0]  err_q;

    rhp_out_t expected_results[$];

    function automatic rhp_prof_t prof_of(logic [15:0] w);
        if (w == PROFILE_ONE_BYTE) return PROF_ONE_BYTE;
        if ((w & PROFILE_TWO_MASK) == PROFILE_TWO_BYTE) return PROF_TWO_BYTE;
        return PROF_NONE;
    endfunction

    task automatic clear_state();
        pos_q = '0; flags_q = '0; marker_q = 1'b0; ptype_q = '0; seq_q = '0; ts_q = '0;
        ssrc_q = '0; cc_q = '0; profile_q = '0; area_q = 0; cursor_q = 0; pend_q = '0;
        stopped_q = 1'b0; err_q = ST_OK;
    endtask

    task automatic parse_byte(input rhp_in_t req);
        int d, size, pos, base, e, rel, hl, id, ln, po, pad, off, len;
        logic rec, hdr;
        int rid, roff, rlen;
        rhp_prof_t kind;
        rhp_out_t r;
        logic [2:0] st;
        d = req.data_byte; size = req.packet_length; pos = pos_q;
        rec = 0; rid = 0; roff = 0; rlen = 0;
        base = 12 + 4 * cc_q;
        if (pos < MAX_BYTES) begin
            if (pos == 0) begin
                flags_q = d[5:4];
                cc_q = d[3:0];
                base = 12 + 4 * cc_q;
                if (size < FIXED_BYTES) err_q = ST_SHORT_FIXED;
                else if (d[7:6] != RTP_VERSION) err_q = ST_BAD_VERSION;
                else if (size < base) err_q = ST_SHORT_CSRC;
                else if (d[4] && size < base + 4) err_q = ST_SHORT_EXT;
            end else if (pos == 1) begin
                marker_q = d[7];
                ptype_q = d[6:0];
            end else if (pos < 4) begin
                seq_q = {seq_q[7:0], d[7:0]};
            end else if (pos < 8) begin
                ts_q = {ts_q[23:0], d[7:0]};
            end else if (pos < 12) begin
                ssrc_q = {ssrc_q[23:0], d[7:0]};
            end
            if (pos != 0 && err_q == ST_OK && flags_q[0]) begin
                e = base + 4;
                kind = prof_of(profile_q);
                if (pos == base || pos == base + 1) begin
                    profile_q = {profile_q[7:0], d[7:0]};
                end else if (pos == base + 2) begin
                    area_q = d << 10;
                end else if (pos == base + 3) begin
                    area_q += d << 2;
                    if (e + area_q > size) err_q = ST_EXT_OVERRUN;
                end else if (pos >= e && pos < e + area_q && !stopped_q
                             && kind != PROF_NONE) begin
                    rel = pos - e;
                    if (pend_q[8]) begin
                        if (cursor_q + 2 + d > area_q) stopped_q = 1'b1;
                        else begin
                            rec = 1; rid = pend_q[7:0]; roff = e + cursor_q + 2;
                            rlen = d; cursor_q += 2 + d;
                        end
                        pend_q = '0;
                    end else if (rel == cursor_q) begin
                        hl = (kind == PROF_ONE_BYTE) ? 1 : 2;
                        if (cursor_q + hl >= area_q) stopped_q = 1'b1;
                        else if (d == 0) cursor_q += 1;
                        else if (kind == PROF_ONE_BYTE) begin
                            id = d >> 4;
                            ln = 1 + (d & 15);
                            if (id == ID_RESERVED || id == 0 || cursor_q + 1 + ln > area_q)
                                stopped_q = 1'b1;
                            else begin
                                rec = 1; rid = id; roff = e + cursor_q + 1;
                                rlen = ln; cursor_q += 1 + ln;
                            end
                        end else pend_q = {1'b1, d[7:0]};
                    end
                end
            end
            pos_q = 12'(pos + 1);
        end
        if (req.last_byte) begin
            st = err_q; pad = 0; off = 0; len = 0;
            hdr = (st == ST_OK || st >= ST_SHORT_EXT);
            po = base;
            if (flags_q[0]) po = base + 4 + area_q;
            if (st == ST_OK) begin
                if (flags_q[1] && po < size) begin
                    pad = d;
                    if (pad == 0) st = ST_ZERO_PAD;
                end
                if (st == ST_OK && po + pad > size) st = ST_PAD_OVERRUN;
                if (st == ST_OK) begin
                    off = po; len = size - po - pad;
                end
            end
            r.is_summary = 1'b1; r.status = st;
            r.marker = hdr ? marker_q : 1'b0; r.ptype = hdr ? ptype_q : 7'd0;
            r.sequence_res = hdr ? seq_q : 16'd0; r.timestamp = hdr ? ts_q : 32'd0;
            r.ssrc = hdr ? ssrc_q : 32'd0; r.csrc_count = hdr ? cc_q : 4'd0;
            r.ext_id = 8'd0; r.offset = 12'(off); r.length = 12'(len);
            r.padding_count = (st == ST_OK || st == ST_PAD_OVERRUN) ? 8'(pad) : 8'd0;
            expected_results.push_back(r);
            clear_state();
        end else if (rec) begin
            r.is_summary = 1'b0; r.status = ST_OK; r.marker = marker_q;
            r.ptype = ptype_q; r.sequence_res = seq_q; r.timestamp = ts_q;
            r.ssrc = ssrc_q; r.csrc_count = cc_q; r.ext_id = 8'(rid);
            r.offset = 12'(roff); r.length = 12'(rlen); r.padding_count = 8'd0;
            expected_results.push_back(r);
        end
    endtask

    initial begin
        error_count = 0;
        clear_state();
    end

    always @(posedge aclk) begin
        rhp_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result %h", $time, m_data);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data !== want) begin
                        error_count++;
                        $display("%0t: mismatch expected %h actual %h", $time, want, m_data);
                        if (m_data.status !== want.status)
                            $display("  status expected %0d actual %0d", want.status,
                                     m_data.status);
                        if (m_data.ext_id !== want.ext_id || m_data.offset !== want.offset ||
                            m_data.length !== want.length)
                            $display("  id/offset/length expected %0d/%0d/%0d actual %0d/%0d/%0d",
                                     want.ext_id, want.offset, want.length,
                                     m_data.ext_id, m_data.offset, m_data.length);
                    end
                end
            end
            if (s_valid && s_ready) parse_byte(s_data);
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives RTP packets byte by byte into the parser and gives the verdict.
// ----------------------------------------------------------------------------
// Directed packets cover every status, both extension profiles, padding and
// stop rules; random packets are mostly well-formed with random extension
// content, plus noise. Sender and receiver idle in several phases.
`timescale 1ns / 1ps

module testbench;
    import rhp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic     aclk = 0;
    logic     aresetn = 0;
    logic     s_valid = 0;
    logic     s_ready;
    rhp_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 0;
    rhp_out_t m_data;
    int       error_count;
    int       pending_count;
    int       send_idle = 0;
    int       recv_stall = 0;
    logic     hold_off = 0;
    int       idle_cycles = 0;

    byte unsigned pkt[$];

    always #2 aclk = ~aclk;

    rtp_header_parser uut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    rhp_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .error_count(error_count), .pending_count(pending_count)
    );

    always @(posedge aclk) begin
        if (hold_off) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // send pkt with stated length; the valid stays high between bytes unless idling
    task automatic send_packet(input int stated_len);
        int i;
        for (i = 0; i < pkt.size(); i++) begin
            while ($urandom_range(99) < send_idle) begin
                s_valid <= 0;
                @(posedge aclk);
            end
            s_valid <= 1;
            s_data.data_byte <= pkt[i];
            s_data.packet_length <= stated_len[11:0];
            s_data.last_byte <= (i == pkt.size() - 1);
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
        end
    endtask

    task automatic build_packet(input int ver, input bit pad_f, input bit ext_f,
                                input int cc, input logic [15:0] profile,
                                input int area_words, input int payload,
                                input int padn, input int mode);
        int i, k, cur, id, ln;
        pkt.delete();
        pkt.push_back({ver[1:0], pad_f, ext_f, cc[3:0]});
        for (i = 1; i < 12 + 4 * cc; i++) pkt.push_back($urandom_range(255));
        if (ext_f) begin
            pkt.push_back(profile[15:8]);
            pkt.push_back(profile[7:0]);
            pkt.push_back(area_words >> 8);
            pkt.push_back(area_words[7:0]);
            cur = 0;
            while (cur < area_words * 4) begin
                k = $urandom_range(9);
                if (mode == 1 || k == 0) begin
                    pkt.push_back($urandom_range(255));
                    cur++;
                end else if (k == 1) begin
                    pkt.push_back(0);
                    cur++;
                end else if (profile == PROFILE_ONE_BYTE) begin
                    id = $urandom_range(14, 1);
                    ln = $urandom_range(15);
                    pkt.push_back({id[3:0], ln[3:0]});
                    cur++;
                    for (i = 0; i <= ln; i++) begin pkt.push_back($urandom_range(255)); cur++; end
                end else begin
                    pkt.push_back($urandom_range(255, 1));
                    ln = $urandom_range(12);
                    pkt.push_back(ln);
                    cur += 2;
                    for (i = 0; i < ln; i++) begin pkt.push_back($urandom_range(255)); cur++; end
                end
            end
            while (pkt.size() > 16 + 4 * cc + area_words * 4) void'(pkt.pop_back());
        end
        for (i = 0; i < payload; i++) pkt.push_back($urandom_range(255));
        if (pad_f) begin
            for (i = 1; i < padn; i++) pkt.push_back(0);
            pkt.push_back(padn);
        end
    endtask

    task automatic random_packet();
        int sel, cc;
        logic [15:0] prof;
        sel = $urandom_range(99);
        cc = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
        case ($urandom_range(3))
            0: prof = PROFILE_TWO_BYTE | $urandom_range(15);
            1: prof = $urandom_range(65535);
            default: prof = PROFILE_ONE_BYTE;
        endcase
        if (sel < 80) begin
            build_packet(2, $urandom_range(1), $urandom_range(3) != 0, cc, prof,
                         $urandom_range(6), $urandom_range(12), $urandom_range(1, 6),
                         $urandom_range(9) == 0);
            send_packet(($urandom_range(15) == 0) ?
                        pkt.size() + $urandom_range(8) - 4 : pkt.size());
        end else begin
            build_packet($urandom_range(3), $urandom_range(1), $urandom_range(1), cc, prof,
                         $urandom_range(3), $urandom_range(8), $urandom_range(255), 1);
            if (pkt.size() > 40) pkt = pkt[0:39];
            pkt[pkt.size() - 1] = $urandom_range(255);
            send_packet($urandom_range(99) < 10 ? 4095 : $urandom_range(1, 60));
        end
    endtask

    task automatic wait_drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int i;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        build_packet(2, 0, 0, 0, 0, 0, 0, 0, 0); send_packet(pkt.size());
        pkt = '{8'h80, 8'h00}; send_packet(2);
        build_packet(1, 0, 0, 0, 0, 0, 4, 0, 0); send_packet(pkt.size());
        build_packet(2, 0, 0, 15, 0, 0, 0, 0, 0); pkt = pkt[0:19]; send_packet(20);
        build_packet(2, 0, 1, 0, PROFILE_ONE_BYTE, 0, 0, 0, 0); send_packet(14);
        build_packet(2, 0, 1, 0, PROFILE_ONE_BYTE, 8, 0, 0, 0); send_packet(40);
        build_packet(2, 1, 0, 0, 0, 0, 4, 1, 0); pkt[pkt.size() - 1] = 0;
        send_packet(pkt.size());
        build_packet(2, 1, 0, 0, 0, 0, 2, 2, 0); pkt[pkt.size() - 1] = 255;
        send_packet(pkt.size());
        build_packet(2, 0, 1, 1, PROFILE_ONE_BYTE, 3, 4, 0, 0); send_packet(pkt.size());
        build_packet(2, 1, 1, 0, PROFILE_TWO_BYTE | 16'hF, 4, 3, 3, 0);
        send_packet(pkt.size());
        pkt = '{8'h90, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'hBE, 8'hDE, 8'h00, 8'h02, 8'hF0, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00};
        send_packet(24);
        pkt[16] = 8'h05; send_packet(24);
        pkt[16] = 8'h00; pkt[17] = 8'h00; pkt[18] = 8'h13; send_packet(24);
        pkt = '{8'hBF, 8'h7F, 8'h00}; send_packet(4095);
        for (i = 0; i < 30; i++) begin pkt.push_back(8'hA5); end
        pkt[0] = 8'h80; send_packet(5);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle = (phase == 1 || phase == 3) ? ((phase == 3) ? 9 : 83) : 0;
            recv_stall = (phase == 2) ? 83 : ((phase == 3) ? 9 : 0);
            if (phase == 1) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            for (i = 0; i < ((phase == 1) ? 3 : 1); i++) random_packet();
            wait_drain();
            for (i = 0; i < 1; i++) random_packet();
        end
        wait_drain();
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
